>>> rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define CPTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CPTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cpts_pkg.sv
// Types, codes and helper functions for the counter priority task scheduler.
// No dependencies; used by the slot cell and the top level.
package cpts_pkg;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_YIELD   = 3'd1;
  localparam logic [2:0] REQ_EXIT    = 3'd2;
  localparam logic [2:0] REQ_PDIS    = 3'd3;
  localparam logic [2:0] REQ_PENA    = 3'd4;
  localparam logic [2:0] REQ_LOAD    = 3'd5;
  localparam logic [2:0] REQ_SIGNAL  = 3'd6;

  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_STOPPED  = 2'd1;
  localparam logic [1:0] ST_ZOMBIE   = 2'd2;
  localparam logic [1:0] ST_WAITING  = 2'd3;

  localparam logic [1:0] SIG_KILL    = 2'd0;
  localparam logic [1:0] SIG_STOP    = 2'd1;
  localparam logic [1:0] SIG_RESUME  = 2'd2;

  localparam logic [7:0] PID_NONE    = 8'hff;

  // Broadcast command to all cells.
  typedef struct packed {
    logic       load;
    logic       post;
    logic       tick;
    logic       yield_c;
    logic       exit_c;
    logic       pdis;
    logic       pena;
    logic       scan;
    logic       recharge;
    logic       fin;
    logic       v;
    logic [7:0] pid;
    logic [3:0] prio;
    logic [7:0] cnt;
    logic [1:0] st;
    logic [7:0] wpid;
    logic [1:0] kind;
    logic [7:0] wake_pid;
  } cmd_t;

  // Per-cell decoded selects.
  typedef struct packed {
    logic tgt;
    logic cur;
    logic step;
    logic best;
  } sel_t;

  // Running best candidate handed down the chain.
  typedef struct packed {
    logic       found;
    logic [7:0] maxc;
  } tok_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] st;
    logic [7:0] cnt;
    logic [3:0] depth;
    logic [7:0] pid;
  } stat_t;

  typedef struct packed {
    logic [1:0] st;
    logic [2:0] pend;
  } sig_t;

  // One pending signal taken: kill before stop before resume.
  function automatic sig_t apply_sig(input logic [1:0] st, input logic [2:0] pend);
    sig_t r;
    r.st   = st;
    r.pend = pend;
    if (pend[0]) begin
      r.st      = ST_ZOMBIE;
      r.pend[0] = 1'b0;
    end else if (pend[1]) begin
      r.st      = ST_STOPPED;
      r.pend[1] = 1'b0;
    end else if (pend[2]) begin
      r.st      = ST_RUNNING;
      r.pend[2] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] recharge(input logic [7:0] cnt, input logic [3:0] prio);
    logic [8:0] s;
    s = {2'b00, cnt[7:1]} + {5'd0, prio};
    return s[8] ? 8'hff : s[7:0];
  endfunction

endpackage

>>> rtl/cpts_if.sv
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on nothing but plain logic types.
interface cpts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [3:0] slot;
  logic       slot_valid_in;
  logic [7:0] task_id;
  logic [3:0] prio;
  logic [7:0] start_counter;
  logic [1:0] task_state;
  logic [7:0] awaited_id;
  logic [1:0] signal_kind;

  modport source (output valid, req_type, slot, slot_valid_in, task_id, prio,
                  start_counter, task_state, awaited_id, signal_kind, input ready);
  modport sink (input valid, req_type, slot, slot_valid_in, task_id, prio,
                start_counter, task_state, awaited_id, signal_kind, output ready);
endinterface

interface cpts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] current_slot;
  logic       switched;
  logic       no_runnable;
  logic [7:0] current_count;

  modport source (output valid, current_slot, switched, no_runnable, current_count,
                  input ready);
  modport sink (input valid, current_slot, switched, no_runnable, current_count,
                output ready);
endinterface

>>> rtl/cpts_cell.sv
// One task slot: holds the slot entry and one stage of the best-slot chain.
// Depends on cpts_pkg.
module cpts_cell
  import cpts_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  sel_t  sel,
  input  tok_t  tok_in,
  output tok_t  tok_out,
  output logic  take,
  output stat_t stat
);

  logic       valid;
  logic [1:0] st;
  logic [7:0] cnt;
  logic [3:0] prio;
  logic [2:0] pend;
  logic [7:0] pid;
  logic [7:0] wpid;
  logic [3:0] depth;
  sig_t       sig;

  assign sig  = apply_sig(st, pend);
  assign take = cmd.scan && sel.step && valid && sig.st == ST_RUNNING &&
                (!tok_in.found || cnt > tok_in.maxc);

  assign stat.valid = valid;
  assign stat.st    = st;
  assign stat.cnt   = cnt;
  assign stat.depth = depth;
  assign stat.pid   = pid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= FIRST;
      st      <= ST_RUNNING;
      cnt     <= 8'd0;
      prio    <= FIRST ? 4'd1 : 4'd0;
      pend    <= 3'd0;
      pid     <= 8'd0;
      wpid    <= 8'd0;
      depth   <= 4'd0;
      tok_out <= '0;
    end else begin
      if (cmd.load && sel.tgt) begin
        valid <= cmd.v;
        pid   <= cmd.pid;
        prio  <= cmd.prio;
        cnt   <= cmd.cnt;
        st    <= cmd.st;
        wpid  <= cmd.wpid;
        pend  <= 3'd0;
        depth <= 4'd0;
      end
      if (cmd.post && sel.tgt) begin
        case (cmd.kind)
          SIG_KILL:   pend <= pend | 3'b001;
          SIG_STOP:   pend <= pend | 3'b010;
          SIG_RESUME: pend <= pend | 3'b100;
          default:    pend <= pend;
        endcase
      end
      if (sel.cur) begin
        if (cmd.tick && cnt != 8'd0) cnt <= cnt - 8'd1;
        if (cmd.yield_c) cnt <= 8'd0;
        if (cmd.exit_c) begin
          st  <= ST_ZOMBIE;
          cnt <= 8'd0;
        end
        if (cmd.pdis && depth != 4'hf) depth <= depth + 4'd1;
        if (cmd.pena && depth != 4'd0) depth <= depth - 4'd1;
      end else if (cmd.exit_c && valid && st == ST_WAITING && wpid == cmd.wake_pid) begin
        st   <= ST_RUNNING;
        wpid <= PID_NONE;
      end
      if (cmd.scan && sel.step) begin
        if (valid) begin
          st   <= sig.st;
          pend <= sig.pend;
        end
        if (take) begin
          tok_out.found <= 1'b1;
          tok_out.maxc  <= cnt;
        end else begin
          tok_out <= tok_in;
        end
      end
      if (cmd.recharge && valid) cnt <= recharge(cnt, prio);
      if (cmd.fin && sel.best) begin
        st   <= sig.st;
        pend <= sig.pend;
      end
    end
  end

endmodule

>>> rtl/counter_priority_task_scheduler_unit.sv
// Requests without reschedule go straight to S_DONE, which posts the result
// once the output is free; a reschedule runs up to MAX_PASSES passes, each set
// by the walk of the best-slot token down the cell chain, one slot per cycle.
// One request at a time; the next one is taken the cycle after the result is
// posted. Synchronous reset: slot 0 valid, priority 1.
module counter_priority_task_scheduler_unit
  import cpts_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int MAX_PASSES = 3
) (
  input logic     clk,
  input logic     rst,
  cpts_in_if.sink   in_ch,
  cpts_out_if.source out_ch
);
  `include "assert_macros.svh"

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(MAX_PASSES) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_RECHG = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state;
  logic [IW-1:0] step;
  logic [PW-1:0] pass;
  logic [IW-1:0] best;
  logic [IW-1:0] old;
  logic [IW-1:0] running;
  logic          none;

  cmd_t  cmd;
  tok_t  tok_in  [SLOTS];
  tok_t  tok_out [SLOTS];
  logic  take    [SLOTS];
  stat_t stat    [SLOTS];
  stat_t cur;
  logic  acc;
  logic  resched;

  assign in_ch.ready = (state == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign cur = stat[running];

  always_comb begin
    cmd          = '0;
    cmd.v        = in_ch.slot_valid_in;
    cmd.pid      = in_ch.task_id;
    cmd.prio     = in_ch.prio;
    cmd.cnt      = in_ch.start_counter;
    cmd.st       = in_ch.task_state;
    cmd.wpid     = in_ch.awaited_id;
    cmd.kind     = in_ch.signal_kind;
    cmd.wake_pid = cur.pid;
    resched      = 1'b0;
    if (acc) begin
      unique case (in_ch.req_type)
        REQ_TICK: begin
          cmd.tick = 1'b1;
          resched  = cur.cnt <= 8'd1 && cur.depth == 4'd0;
        end
        REQ_YIELD: begin
          cmd.yield_c = 1'b1;
          resched     = 1'b1;
        end
        REQ_EXIT: begin
          cmd.exit_c = 1'b1;
          resched    = 1'b1;
        end
        REQ_PDIS:   cmd.pdis = 1'b1;
        REQ_PENA:   cmd.pena = 1'b1;
        REQ_LOAD:   cmd.load = 1'b1;
        REQ_SIGNAL: cmd.post = 1'b1;
        default: ;
      endcase
    end
    cmd.scan     = (state == S_SCAN);
    cmd.recharge = (state == S_RECHG);
    cmd.fin      = (state == S_FINAL);
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    sel_t sel;
    assign sel.tgt  = (32'(in_ch.slot) == i);
    assign sel.cur  = (32'(running) == i);
    assign sel.step = (32'(step) == i);
    assign sel.best = (32'(best) == i);
    if (i == 0) begin : g_head
      assign tok_in[i] = '0;
    end else begin : g_link
      assign tok_in[i] = tok_out[i-1];
    end
    cpts_cell #(.FIRST(i == 0)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .sel     (sel),
      .tok_in  (tok_in[i]),
      .tok_out (tok_out[i]),
      .take    (take[i]),
      .stat    (stat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      pass         <= '0;
      best         <= '0;
      old          <= '0;
      running      <= '0;
      none         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_DONE) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            old  <= running;
            none <= 1'b0;
            step <= '0;
            pass <= '0;
            state <= resched ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (take[step]) best <= step;
          step <= step + 1'b1;
          if (step == IW'(SLOTS - 1)) state <= S_EVAL;
        end
        S_EVAL: begin
          if (tok_out[SLOTS-1].found) begin
            state <= S_FINAL;
          end else if (32'(pass) + 1 < MAX_PASSES) begin
            state <= S_RECHG;
          end else begin
            none  <= 1'b1;
            state <= S_DONE;
          end
        end
        S_RECHG: begin
          pass  <= pass + 1'b1;
          step  <= '0;
          state <= S_SCAN;
        end
        S_FINAL: state <= S_CHECK;
        S_CHECK: begin
          if (stat[best].st == ST_RUNNING) running <= best;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid         <= 1'b1;
            out_ch.current_slot  <= 4'(running);
            out_ch.switched      <= (running != old);
            out_ch.no_runnable   <= none;
            out_ch.current_count <= cur.cnt;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CPTS_ASSERT(a_yield_scans,
    (acc && in_ch.req_type == REQ_YIELD) |=> state == S_SCAN,
    "yield did not start a reschedule")
  `CPTS_ASSERT(a_scan_full_row,
    state == S_EVAL |-> $past(step) == IW'(SLOTS - 1),
    "pass ended before the last slot")
  `CPTS_ASSERT(a_none_after_all,
    (state == S_DONE && none) |-> 32'(pass) == MAX_PASSES - 1,
    "no_runnable set before all passes ran")

endmodule
